### src/stereo_biquad_ramped_mix_defines.svh
// Assertion macros for the ramped stereo biquad.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef STEREO_BIQUAD_RAMPED_MIX_DEFINES_SVH
`define STEREO_BIQUAD_RAMPED_MIX_DEFINES_SVH

// Implication into the next cycle, masked while in reset
`define SBRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is applied
`define SBRM_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

### src/sbrm_pkg.sv
// ----------------------------------------------------------------------------
// sbrm_pkg
// Shared constants and register index codes for the ramped stereo biquad.
// ----------------------------------------------------------------------------
package sbrm_pkg;

  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int COEF_BITS_DEF    = 32;
  localparam int MAX_CHANNELS_DEF = 2;

  localparam int NCOEF     = 5;
  localparam int MIX_BITS  = 17;
  localparam int RAMP_BITS = 16;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [MIX_BITS-1:0] MIX_ONE = 17'd65536;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_B0   = 3'd0,
    CFG_B1   = 3'd1,
    CFG_B2   = 3'd2,
    CFG_A1   = 3'd3,
    CFG_A2   = 3'd4,
    CFG_MIX  = 3'd5,
    CFG_RAMP = 3'd6,
    CFG_HARD = 3'd7
  } cfg_idx_t;

endpackage

### src/sbrm_ser_mul.sv
// ----------------------------------------------------------------------------
// sbrm_ser_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add.
// ----------------------------------------------------------------------------
module sbrm_ser_mul #(
  parameter int AW = 33,
  parameter int BW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic                 done,
  output logic signed [AW+BW-1:0] p
);

  localparam int PW   = AW + BW;
  localparam int CNTW = $clog2(BW);

  logic signed [PW-1:0] acc_r;
  logic signed [PW-1:0] a_r;
  logic [BW-1:0]        b_r;
  logic [CNTW-1:0]      cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic                 last;

  assign last = (cnt_r == CNTW'(BW - 1));

  // Multiplier MSB carries negative weight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && !start && last;
      if (start) begin
        acc_r <= '0;
        a_r   <= PW'(a);
        b_r   <= b;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (b_r[0]) begin
          acc_r <= last ? (acc_r - a_r) : (acc_r + a_r);
        end
        a_r   <= a_r <<< 1;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

### src/sbrm_ser_div.sv
// ----------------------------------------------------------------------------
// sbrm_ser_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbrm_ser_div #(
  parameter int NW = 57,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW);

  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [NW-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;
  logic [DW:0]     trial;
  logic            fits;

  // Bring down the next dividend bit and try a subtract
  assign trial = {rem_r, q_r[NW-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && !start && (cnt_r == CNTW'(NW - 1));
      if (start) begin
        rem_r <= '0;
        den_r <= den;
        q_r   <= num;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= fits ? DW'(trial - {1'b0, den_r}) : DW'(trial);
        q_r   <= {q_r[NW-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(NW - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

### src/stereo_biquad_ramped_mix.sv
// ----------------------------------------------------------------------------
// stereo_biquad_ramped_mix
// Stereo direct-form-1 biquad with ramped coefficients and dry/wet mix.
// ----------------------------------------------------------------------------
// One frame is processed at a time. Each frame first interpolates the five
// coefficients and the mix (a serial multiply then a serial divide each, or a
// direct pick of start or target per coefficient in hard-switch mode), then
// runs five multiply-accumulates and two mix products per active channel. All
// products go through one bit-serial multiplier and all quotients through one
// bit-serial divider. A new frame is taken while the previous result still
// waits at the output.
module stereo_biquad_ramped_mix #(
  parameter int SAMPLE_BITS  = sbrm_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS    = sbrm_pkg::COEF_BITS_DEF,
  parameter int MAX_CHANNELS = sbrm_pkg::MAX_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  input  logic                          in_both_channels,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  input  logic                          cfg_we,
  input  logic [sbrm_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [COEF_BITS-1:0]          cfg_wdata
);

  localparam int CF    = COEF_BITS - 5;
  localparam int AW    = (COEF_BITS + 1 > SAMPLE_BITS) ? COEF_BITS + 1 : SAMPLE_BITS;
  localparam int BW    = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
  localparam int PW    = AW + BW;
  localparam int ACCW  = PW + 3;
  localparam int MIXW  = sbrm_pkg::MIX_BITS;
  localparam int RW    = sbrm_pkg::RAMP_BITS;
  localparam int NC    = sbrm_pkg::NCOEF;
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Interpolation slots: five coefficients then the mix
  localparam logic [2:0] LERP_MIX  = 3'd5;
  localparam logic [2:0] LERP_DONE = 3'd6;

  // Filter terms
  localparam logic [2:0] TERM_X0 = 3'd0;
  localparam logic [2:0] TERM_X1 = 3'd1;
  localparam logic [2:0] TERM_X2 = 3'd2;
  localparam logic [2:0] TERM_Y1 = 3'd3;
  localparam logic [2:0] TERM_Y2 = 3'd4;

  localparam logic signed [ACCW-1:0] WET_RND = ACCW'(1) <<< (CF - 1);
  localparam logic signed [ACCW-1:0] MIX_RND = ACCW'(32768);
  localparam logic signed [ACCW-1:0] SAT_HI  =
    {{(ACCW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACCW-1:0] SAT_LO  = ~SAT_HI;
  localparam logic [COEF_BITS-1:0]  B0_RESET = COEF_BITS'(1) << CF;

  typedef enum logic [3:0] {
    S_IDLE, S_LERP, S_LMUL, S_LDIV, S_FILT, S_FMUL,
    S_WET, S_MIX, S_MMUL, S_CHAN, S_RAMP, S_DONE
  } state_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_s(
    input logic signed [ACCW-1:0] v
  );
    logic signed [ACCW-1:0] c;
    c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return c[SAMPLE_BITS-1:0];
  endfunction

  // Configuration registers
  logic signed [COEF_BITS-1:0] tgt_coef_r [NC];
  logic [MIXW-1:0]             tgt_mix_r;
  logic [RW-1:0]               ramp_r;
  logic                        hard_r;

  // Ramp state
  logic signed [COEF_BITS-1:0] start_coef_r [NC];
  logic [MIXW-1:0]             start_mix_r;
  logic [RW-1:0]               frame_r;

  // Filter history
  logic signed [SAMPLE_BITS-1:0] xh1_r [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] xh2_r [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] yh1_r [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] yh2_r [MAX_CHANNELS];

  // Per-frame working registers
  state_t                        state_r;
  logic [2:0]                    k_r;
  logic [2:0]                    j_r;
  logic [CHW-1:0]                ch_r;
  logic                          both_r;
  logic                          neg_r;
  logic signed [SAMPLE_BITS-1:0] x_r [2];
  logic signed [SAMPLE_BITS-1:0] y_r [2];
  logic signed [COEF_BITS-1:0]   coef_w_r [NC];
  logic [MIXW-1:0]               mix_w_r;
  logic signed [ACCW-1:0]        acc_r;
  logic signed [SAMPLE_BITS-1:0] wet_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_l_r;
  logic signed [SAMPLE_BITS-1:0] out_r_r;
  logic                          out_load;

  // Finished frame moves into the output register once it is free
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Ramp position
  logic [RW-1:0]   r_eff;
  logic [RW-1:0]   f_eff;
  logic [RW:0]     f1;
  logic            half_lo;
  logic            ramp_end;
  logic [MIXW-1:0] tgt_mix_c;

  assign r_eff     = (ramp_r == '0) ? RW'(1) : ramp_r;
  assign f_eff     = (frame_r >= r_eff) ? (r_eff - 1'b1) : frame_r;
  assign f1        = {1'b0, f_eff} + 1'b1;
  assign half_lo   = ({f1, 1'b0} < {2'b00, r_eff});
  assign ramp_end  = (({1'b0, frame_r} + 1'b1) >= {1'b0, r_eff});
  assign tgt_mix_c = (tgt_mix_r > sbrm_pkg::MIX_ONE) ? sbrm_pkg::MIX_ONE : tgt_mix_r;

  // Interpolation operands for slot k
  logic signed [COEF_BITS-1:0] s_sel;
  logic signed [COEF_BITS-1:0] t_sel;
  logic signed [AW-1:0]        d_sel;

  always_comb begin
    if (k_r == LERP_MIX) begin
      s_sel = COEF_BITS'(start_mix_r);
      t_sel = COEF_BITS'(tgt_mix_c);
    end else begin
      s_sel = start_coef_r[k_r];
      t_sel = tgt_coef_r[k_r];
    end
  end

  assign d_sel = AW'(t_sel) - AW'(s_sel);

  // Sample feeding the current filter term
  logic signed [SAMPLE_BITS-1:0] samp_sel;

  always_comb begin
    case (j_r)
      TERM_X0: samp_sel = x_r[ch_r];
      TERM_X1: samp_sel = xh1_r[ch_r];
      TERM_X2: samp_sel = xh2_r[ch_r];
      TERM_Y1: samp_sel = yh1_r[ch_r];
      TERM_Y2: samp_sel = yh2_r[ch_r];
      default: samp_sel = '0;
    endcase
  end

  // Shared multiplier and divider
  logic                 mul_start;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic                 mul_done;
  logic signed [PW-1:0] mul_p;
  logic                 div_start;
  logic [PW-1:0]        div_num;
  logic                 div_done;
  logic [PW-1:0]        div_quo;
  logic [MIXW-1:0]      mix_comp;

  assign mix_comp = sbrm_pkg::MIX_ONE - mix_w_r;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = d_sel;
    mul_b     = BW'($signed({1'b0, f1}));
    case (state_r)
      S_LERP: begin
        mul_start = (k_r != LERP_DONE) && !(hard_r && (k_r != LERP_MIX));
      end
      S_FILT: begin
        mul_start = 1'b1;
        mul_a     = AW'(coef_w_r[j_r]);
        mul_b     = BW'(samp_sel);
      end
      S_MIX: begin
        mul_start = 1'b1;
        if (j_r == TERM_X0) begin
          mul_a = AW'(x_r[ch_r]);
          mul_b = BW'($signed({1'b0, mix_comp}));
        end else begin
          mul_a = AW'(wet_r);
          mul_b = BW'($signed({1'b0, mix_w_r}));
        end
      end
      default: ;
    endcase
  end

  assign div_start = (state_r == S_LMUL) && mul_done;
  assign div_num   = mul_p[PW-1] ? PW'(-mul_p) : PW'(mul_p);

  sbrm_ser_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  sbrm_ser_div #(.NW(PW), .DW(RW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (r_eff),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Interpolated value once the quotient is in
  logic signed [PW-1:0] lerp_q;
  logic signed [PW-1:0] lerp_res;

  assign lerp_q   = neg_r ? -$signed(div_quo) : $signed(div_quo);
  assign lerp_res = PW'(s_sel) + lerp_q;

  // Wet sample and mixed output from the accumulator
  logic signed [ACCW-1:0] wet_sum;
  logic signed [ACCW-1:0] mix_sum;

  assign wet_sum = (acc_r + WET_RND) >>> CF;
  assign mix_sum = (acc_r + MIX_RND) >>> 16;

  // Frame sequencer, configuration and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        tgt_coef_r[i]   <= (i == 0) ? B0_RESET : '0;
        start_coef_r[i] <= (i == 0) ? B0_RESET : '0;
      end
      tgt_mix_r   <= '0;
      ramp_r      <= RW'(1);
      hard_r      <= 1'b0;
      start_mix_r <= '0;
      frame_r     <= '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        xh1_r[c] <= '0;
        xh2_r[c] <= '0;
        yh1_r[c] <= '0;
        yh2_r[c] <= '0;
      end
    end else begin
      // Register writes
      if (cfg_we) begin
        case (sbrm_pkg::cfg_idx_t'(cfg_addr))
          sbrm_pkg::CFG_B0:   tgt_coef_r[0] <= cfg_wdata;
          sbrm_pkg::CFG_B1:   tgt_coef_r[1] <= cfg_wdata;
          sbrm_pkg::CFG_B2:   tgt_coef_r[2] <= cfg_wdata;
          sbrm_pkg::CFG_A1:   tgt_coef_r[3] <= cfg_wdata;
          sbrm_pkg::CFG_A2:   tgt_coef_r[4] <= cfg_wdata;
          sbrm_pkg::CFG_MIX:  tgt_mix_r     <= cfg_wdata[MIXW-1:0];
          sbrm_pkg::CFG_RAMP: ramp_r        <= cfg_wdata[RW-1:0];
          sbrm_pkg::CFG_HARD: hard_r        <= cfg_wdata[0];
          default: ;
        endcase
      end

      // Output valid: set on load, cleared by the handshake
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r[0]  <= in_left_in;
            x_r[1]  <= in_right_in;
            y_r[0]  <= in_left_in;
            y_r[1]  <= in_right_in;
            both_r  <= in_both_channels && (MAX_CHANNELS > 1);
            k_r     <= '0;
            state_r <= S_LERP;
          end
        end

        // Interpolate one slot, or select a coefficient in hard-switch mode
        S_LERP: begin
          if (k_r == LERP_DONE) begin
            ch_r    <= '0;
            j_r     <= TERM_X0;
            acc_r   <= '0;
            state_r <= S_FILT;
          end else if (hard_r && (k_r != LERP_MIX)) begin
            coef_w_r[k_r] <= half_lo ? s_sel : t_sel;
            k_r           <= k_r + 1'b1;
          end else begin
            state_r <= S_LMUL;
          end
        end

        S_LMUL: begin
          if (mul_done) begin
            neg_r   <= mul_p[PW-1];
            state_r <= S_LDIV;
          end
        end

        S_LDIV: begin
          if (div_done) begin
            if (k_r == LERP_MIX) begin
              mix_w_r <= lerp_res[MIXW-1:0];
            end else begin
              coef_w_r[k_r] <= lerp_res[COEF_BITS-1:0];
            end
            k_r     <= k_r + 1'b1;
            state_r <= S_LERP;
          end
        end

        S_FILT: state_r <= S_FMUL;

        // Feedback terms are subtracted
        S_FMUL: begin
          if (mul_done) begin
            acc_r <= (j_r >= TERM_Y1) ? (acc_r - ACCW'(mul_p)) : (acc_r + ACCW'(mul_p));
            if (j_r == TERM_Y2) begin
              state_r <= S_WET;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_FILT;
            end
          end
        end

        S_WET: begin
          wet_r   <= sat_s(wet_sum);
          acc_r   <= '0;
          j_r     <= TERM_X0;
          state_r <= S_MIX;
        end

        S_MIX: state_r <= S_MMUL;

        S_MMUL: begin
          if (mul_done) begin
            acc_r <= acc_r + ACCW'(mul_p);
            if (j_r == TERM_X0) begin
              j_r     <= TERM_X1;
              state_r <= S_MIX;
            end else begin
              state_r <= S_CHAN;
            end
          end
        end

        // Close out one channel and shift its history
        S_CHAN: begin
          y_r[ch_r]   <= sat_s(mix_sum);
          xh2_r[ch_r] <= xh1_r[ch_r];
          xh1_r[ch_r] <= x_r[ch_r];
          yh2_r[ch_r] <= yh1_r[ch_r];
          yh1_r[ch_r] <= wet_r;
          if (both_r && (ch_r == '0)) begin
            ch_r    <= CHW'(1);
            j_r     <= TERM_X0;
            acc_r   <= '0;
            state_r <= S_FILT;
          end else begin
            state_r <= S_RAMP;
          end
        end

        // Advance the ramp; at its end the targets become the new start set
        S_RAMP: begin
          if (ramp_end) begin
            for (int i = 0; i < NC; i++) begin
              start_coef_r[i] <= tgt_coef_r[i];
            end
            start_mix_r <= tgt_mix_c;
            frame_r     <= '0;
          end else begin
            frame_r <= frame_r + 1'b1;
          end
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (out_load) begin
            out_l_r <= y_r[0];
            out_r_r <= y_r[1];
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_left_out  = out_l_r;
  assign out_right_out = out_r_r;

endmodule

### src/sbrm_checker.sv
// ----------------------------------------------------------------------------
// sbrm_checker
// Port-level checks for the ramped stereo biquad, bound to the top level.
// ----------------------------------------------------------------------------
`include "stereo_biquad_ramped_mix_defines.svh"

module sbrm_checker #(
  parameter int SAMPLE_BITS = sbrm_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_left_out,
  input logic [SAMPLE_BITS-1:0] out_right_out
);

  // A stalled result holds its value
  `SBRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_left_out) && $stable(out_right_out), "result changed while stalled")

  // A frame in progress blocks the next transaction
  `SBRM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken during a frame")

  // No result straight out of reset
  `SBRM_ASSERT_AFTER_RESET(a_reset_empty, !out_valid, "result valid after reset")

endmodule

bind stereo_biquad_ramped_mix sbrm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sbrm_checker (.*);

### tb/stereo_biquad_ramped_mix_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_biquad_ramped_mix_test
// Self-checking bench for the ramped stereo biquad with dry/wet mix. Frames
// are sent over the valid/ready input channel. A predictor built into the
// bench computes each expected output frame. Results are checked in order
// under several idling patterns and register settings.
// ----------------------------------------------------------------------------
module stereo_biquad_ramped_mix_test;

  localparam int SB = 24;
  localparam int CB = 32;
  localparam int CF = CB - 5;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;
  localparam longint SMAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  typedef struct {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SB-1:0] in_left_in = '0;
  logic signed [SB-1:0] in_right_in = '0;
  logic in_both_channels = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SB-1:0] out_left_out;
  logic signed [SB-1:0] out_right_out;
  logic cfg_we = 1'b0;
  logic [sbrm_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CB-1:0] cfg_wdata = '0;

  // Predictor copy of registers and filter state
  longint coef_tgt[sbrm_pkg::NCOEF];
  longint coef_start[sbrm_pkg::NCOEF];
  longint mix_tgt, ramp_len, hard_sw, mix_start, frame_idx;
  longint xh1[2], xh2[2], yh1[2], yh2[2];

  frame_t expected_frames[$];
  int errors = 0;
  int frames_sent = 0;
  int frames_checked = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int stall_cnt = 0;

  stereo_biquad_ramped_mix dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---- predictor ----
  function automatic longint ramp_point(longint s, longint t, longint f1, longint r);
    longint d;
    d = t - s;
    return s + (d / r) * f1 + ((d % r) * f1) / r;
  endfunction

  function automatic longint sat(longint v);
    return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
  endfunction

  function automatic longint clamp_mix(longint m);
    return m > 65536 ? 64'sd65536 : m;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < sbrm_pkg::NCOEF; i++) begin
      coef_tgt[i] = 0;
    end
    coef_tgt[0] = 64'sd1 <<< CF;
    mix_tgt = 0;
    ramp_len = 1;
    hard_sw = 0;
    for (int i = 0; i < sbrm_pkg::NCOEF; i++) coef_start[i] = coef_tgt[i];
    mix_start = 0;
    frame_idx = 0;
    for (int c = 0; c < 2; c++) begin
      xh1[c] = 0; xh2[c] = 0; yh1[c] = 0; yh2[c] = 0;
    end
  endfunction

  function automatic frame_t filter_frame(logic signed [SB-1:0] l, logic signed [SB-1:0] r,
                                          logic both);
    longint rr, f, mix, acc, wet, mixed;
    longint k[sbrm_pkg::NCOEF];
    longint x[2], y[2];
    frame_t res;
    rr = (ramp_len == 0) ? 1 : ramp_len;
    f = (frame_idx >= rr) ? rr - 1 : frame_idx;
    for (int i = 0; i < sbrm_pkg::NCOEF; i++) begin
      if (hard_sw != 0) k[i] = (2 * (f + 1) < rr) ? coef_start[i] : coef_tgt[i];
      else k[i] = ramp_point(coef_start[i], coef_tgt[i], f + 1, rr);
    end
    mix = ramp_point(mix_start, clamp_mix(mix_tgt), f + 1, rr);
    x[0] = l; x[1] = r;
    y[0] = x[0]; y[1] = x[1];
    for (int c = 0; c < (both ? 2 : 1); c++) begin
      acc = k[0] * x[c] + k[1] * xh1[c] + k[2] * xh2[c] - k[3] * yh1[c] - k[4] * yh2[c];
      acc = acc + (64'sd1 <<< (CF - 1));
      wet = sat(acc >>> CF);
      xh2[c] = xh1[c]; xh1[c] = x[c];
      yh2[c] = yh1[c]; yh1[c] = wet;
      mixed = x[c] * (65536 - mix) + wet * mix + 32768;
      y[c] = sat(mixed >>> 16);
    end
    if (frame_idx + 1 >= rr) begin
      for (int i = 0; i < sbrm_pkg::NCOEF; i++) coef_start[i] = coef_tgt[i];
      mix_start = clamp_mix(mix_tgt);
      frame_idx = 0;
    end else begin
      frame_idx = (frame_idx + 1) & 16'hffff;
    end
    res.left = y[0][SB-1:0];
    res.right = y[1][SB-1:0];
    return res;
  endfunction

  // ---- stimulus helpers ----
  task automatic write_reg(sbrm_pkg::cfg_idx_t idx, logic [CB-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      sbrm_pkg::CFG_MIX:  mix_tgt = val[sbrm_pkg::MIX_BITS-1:0];
      sbrm_pkg::CFG_RAMP: ramp_len = val[sbrm_pkg::RAMP_BITS-1:0];
      sbrm_pkg::CFG_HARD: hard_sw = val[0];
      default:            coef_tgt[idx] = longint'($signed(val));
    endcase
  endtask

  task automatic send_frame(logic [SB-1:0] l, logic [SB-1:0] r, logic both);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_left_in <= l;
    in_right_in <= r;
    in_both_channels <= both;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    expected_frames.push_back(filter_frame(l, r, both));
    frames_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic random_frame();
    send_frame(SB'($urandom), SB'($urandom), $urandom_range(3) != 0);
  endtask

  // ---- tests ----
  task automatic test_directed();
    send_frame(24'h7fffff, 24'h800000, 1'b1);
    send_frame(24'h800000, 24'h7fffff, 1'b1);
    send_frame(24'h123456, 24'hfedcba, 1'b0);
    drain();
    // extreme coefficients, full wet, zero ramp length
    write_reg(sbrm_pkg::CFG_B0, 32'h7fffffff);
    write_reg(sbrm_pkg::CFG_B1, 32'h80000000);
    write_reg(sbrm_pkg::CFG_B2, 32'h08000000);
    write_reg(sbrm_pkg::CFG_A1, 32'hf8000000);
    write_reg(sbrm_pkg::CFG_A2, 32'h04000000);
    write_reg(sbrm_pkg::CFG_MIX, 32'h10000);
    write_reg(sbrm_pkg::CFG_RAMP, 32'h0);
    send_frame(24'h7fffff, 24'h7fffff, 1'b1);
    send_frame(24'h800000, 24'h000001, 1'b1);
    send_frame(24'h000000, 24'h800000, 1'b0);
    drain();
    // mix above one, hard switch over a short ramp
    write_reg(sbrm_pkg::CFG_MIX, 32'h1ffff);
    write_reg(sbrm_pkg::CFG_HARD, 32'h1);
    write_reg(sbrm_pkg::CFG_RAMP, 32'h4);
    write_reg(sbrm_pkg::CFG_B0, 32'h04000000);
    repeat (5) random_frame();
    drain();
    // lower the ramp length while part way through a ramp
    write_reg(sbrm_pkg::CFG_HARD, 32'h0);
    write_reg(sbrm_pkg::CFG_RAMP, 32'h8);
    write_reg(sbrm_pkg::CFG_MIX, 32'h8000);
    repeat (4) random_frame();
    drain();
    write_reg(sbrm_pkg::CFG_RAMP, 32'h2);
    repeat (3) random_frame();
    drain();
    write_reg(sbrm_pkg::CFG_RAMP, 32'hffff);
    repeat (3) random_frame();
    drain();
  endtask

  task automatic random_settings();
    for (int i = 0; i < sbrm_pkg::NCOEF; i++) begin
      if ($urandom_range(4) == 0) write_reg(sbrm_pkg::cfg_idx_t'(i), $urandom);
      else write_reg(sbrm_pkg::cfg_idx_t'(i),
                     32'($signed($urandom_range(32'h20000000)) - 32'sh10000000));
    end
    write_reg(sbrm_pkg::CFG_MIX, $urandom_range(3) == 0 ? $urandom : $urandom_range(65536));
    case ($urandom_range(5))
      0: write_reg(sbrm_pkg::CFG_RAMP, 32'h0);
      1: write_reg(sbrm_pkg::CFG_RAMP, 32'hffff);
      2: write_reg(sbrm_pkg::CFG_RAMP, $urandom);
      default: write_reg(sbrm_pkg::CFG_RAMP, $urandom_range(1, 9));
    endcase
    write_reg(sbrm_pkg::CFG_HARD, $urandom);
  endtask

  task automatic test_random(int send_pct, int stall_pct, int count);
    sender_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 0) begin
        drain();
        random_settings();
      end
      random_frame();
    end
    drain();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = LONG_HOLD;
    repeat (6) random_frame();
    drain();
    // sender waits for every result before each item
    repeat (4) begin
      random_frame();
      drain();
    end
  endtask

  // ---- result side: ready pattern and checking ----
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want,
             frames_checked);
    errors++;
  endtask

  always @(posedge clk) begin
    frame_t want;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        want = expected_frames.pop_front();
        if (out_left_out !== want.left)
          report_mismatch("left_out", out_left_out, want.left);
        if (out_right_out !== want.right)
          report_mismatch("right_out", out_right_out, want.right);
      end
      frames_checked++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: cycles with work pending but no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && expected_frames.size() == 0)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= STALL_LIMIT + LONG_HOLD) begin
        $display("watchdog expired, %0d results outstanding", expected_frames.size());
        $display("** stereo_biquad_ramped_mix: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 150);
    test_random(74, 0, 150);
    test_random(0, 74, 150);
    test_random(20, 20, 150);
    test_backpressure();
    drain();
    repeat (1000) @(posedge clk);
    $display("covered %0d frames: extremes, mono and stereo, hard switch, zero and long ramps,",
             frames_sent);
    $display("mix clamping, shortened ramps, idling sender/receiver and a full back-pressure stall");
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("** stereo_biquad_ramped_mix: PASSED **");
    end else begin
      $display("** stereo_biquad_ramped_mix: FAILED **");
    end
    $finish;
  end

endmodule
